// ----- hdl/lpd_pkg.sv -----
package lpd_pkg;

  // length header size in bytes
  localparam int unsigned HdrBytes = 4;

  // default depth of the result queue between front and outputs
  localparam int unsigned QueueDepthDef = 4;

  // configuration register map
  localparam int unsigned CfgAddrW = 3;
  localparam int unsigned CfgDataW = 32;

  typedef enum logic [0:0] {
    RegLengthBigEndian = 1'b0,
    RegUnused          = 1'b1
  } reg_index_e;

  // one result item as it travels from front to back
  typedef struct packed {
    logic [7:0]  payload_byte;
    logic        frame_first;
    logic        frame_last;
    logic        frame_empty;
    logic [31:0] frame_size;
  } result_t;

endpackage

// ----- hdl/length_prefix_deframer.sv -----
// length prefix deframer
// input side is a queue: in_byte_i is taken at an edge with push high and
// full low, one raw stream byte per item. every frame is a 4-byte length
// header in the configured byte order followed by that many payload bytes.
// result side is a queue: while empty is low the oldest result stands on
// the payload_byte_o/frame_*_o ports and pop high takes it.
// header bytes give no result; each payload byte gives one result, and a
// zero length header gives one empty-frame marker on its last byte.
// latency: on an empty queue a result is on the outputs from the edge
// that takes its byte and can be popped at the next edge.
// throughput: one byte every cycle unless full; the front never holds off
// input and the result queue (QueueDepth entries) sits between it and
// the outputs, so full rises only after QueueDepth results wait unpopped
// while the receiver stalls; input is then held off until a pop.
// configuration: APB register 0 at byte address 0, bit 0 = big-endian
// length header; write it only while the block is idle.
// reset: byte order little-endian, header count zero, queue empty.
module length_prefix_deframer import lpd_pkg::*; #(
  parameter int unsigned QueueDepth = QueueDepthDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // byte input
  input  logic                push,
  output logic                full,
  input  logic [7:0]          in_byte_i,
  // results
  output logic                empty,
  input  logic                pop,
  output logic [7:0]          payload_byte_o,
  output logic                frame_first_o,
  output logic                frame_last_o,
  output logic                frame_empty_o,
  output logic [31:0]         frame_size_o,
  // configuration
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [CfgAddrW-1:0] paddr,
  input  logic [CfgDataW-1:0] pwdata,
  output logic [CfgDataW-1:0] prdata,
  output logic                pready
);

  logic       big_endian_q, big_endian_d;
  logic       cfg_wr;
  reg_index_e cfg_idx;
  logic       accept;
  logic       res_valid;
  result_t    res;
  result_t    head;

  // configuration register
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = reg_index_e'(paddr[CfgAddrW-1:2]);

  always_comb begin
    big_endian_d = big_endian_q;
    if (cfg_wr && (cfg_idx == RegLengthBigEndian)) begin
      big_endian_d = pwdata[0];
    end
  end

  always_comb begin
    unique case (cfg_idx)
      RegLengthBigEndian: prdata = {{(CfgDataW-1){1'b0}}, big_endian_q};
      default:            prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      big_endian_q <= 1'b0;
    end else begin
      big_endian_q <= big_endian_d;
    end
  end

  // front: header tracking and result building
  assign accept = push && !full;

  lpd_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .in_byte_i    (in_byte_i),
    .big_endian_i (big_endian_q),
    .res_valid_o  (res_valid),
    .res_o        (res)
  );

  // back: result queue feeding the outputs
  lpd_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (res_valid),
    .wr_data_i (res),
    .rd_i      (pop),
    .rd_data_o (head),
    .full_o    (full),
    .empty_o   (empty)
  );

  assign payload_byte_o = head.payload_byte;
  assign frame_first_o  = head.frame_first;
  assign frame_last_o   = head.frame_last;
  assign frame_empty_o  = head.frame_empty;
  assign frame_size_o   = head.frame_size;

`ifndef SYNTHESIS
  // an empty-frame marker is always a whole frame of size zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && frame_empty_o) |->
      (frame_first_o && frame_last_o && (frame_size_o == 32'd0)))
    else $error("malformed empty-frame marker");

  // an item taken on an empty queue with a result shows next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (empty && res_valid) |=> !empty)
    else $error("result not visible after accept");

  // a register write lands in the byte order bit
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cfg_wr && (cfg_idx == RegLengthBigEndian)) |=> (big_endian_q == $past(pwdata[0])))
    else $error("byte order register not written");
`endif

endmodule

// ----- hdl/lpd_front.sv -----
module lpd_front import lpd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       accept_i,
  input  logic [7:0] in_byte_i,
  input  logic       big_endian_i,
  output logic       res_valid_o,
  output result_t    res_o
);

  localparam int unsigned IdxW = $clog2(HdrBytes);

  logic [IdxW-1:0] seen_q, seen_d;
  logic            in_payload_q, in_payload_d;
  logic [31:0]     accum_q, accum_d;
  logic [31:0]     left_q, left_d;
  logic            first_q, first_d;

  logic [31:0]     accum_hdr;
  logic            hdr_done;
  logic            pay_last;

  // header byte placed by the byte order in force at its arrival
  always_comb begin
    if (big_endian_i) begin
      accum_hdr = {accum_q[23:0], in_byte_i};
    end else begin
      accum_hdr = accum_q | ({24'd0, in_byte_i} << {seen_q, 3'b000});
    end
  end

  assign hdr_done = (seen_q == IdxW'(HdrBytes - 1));
  assign pay_last = (left_q <= 32'd1);

  // next state of the header and payload tracking
  always_comb begin
    seen_d       = seen_q;
    in_payload_d = in_payload_q;
    accum_d      = accum_q;
    left_d       = left_q;
    first_d      = first_q;
    if (accept_i) begin
      if (!in_payload_q) begin
        accum_d = accum_hdr;
        if (!hdr_done) begin
          seen_d = seen_q + IdxW'(1);
        end else begin
          seen_d = '0;
          if (accum_hdr != 32'd0) begin
            in_payload_d = 1'b1;
            left_d       = accum_hdr;
            first_d      = 1'b1;
          end
        end
      end else begin
        first_d = 1'b0;
        if (left_q != 32'd0) begin
          left_d = left_q - 32'd1;
        end
        if (pay_last) begin
          in_payload_d = 1'b0;
          left_d       = '0;
          accum_d      = '0;
          seen_d       = '0;
        end
      end
    end
  end

  // result item for the accepted byte
  always_comb begin
    res_valid_o = 1'b0;
    res_o       = '0;
    if (accept_i) begin
      if (in_payload_q) begin
        res_valid_o        = 1'b1;
        res_o.payload_byte = in_byte_i;
        res_o.frame_first  = first_q;
        res_o.frame_last   = pay_last;
        res_o.frame_empty  = 1'b0;
        res_o.frame_size   = accum_q;
      end else if (hdr_done && (accum_hdr == 32'd0)) begin
        res_valid_o        = 1'b1;
        res_o.frame_first  = 1'b1;
        res_o.frame_last   = 1'b1;
        res_o.frame_empty  = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q       <= '0;
      in_payload_q <= 1'b0;
      accum_q      <= '0;
      left_q       <= '0;
      first_q      <= 1'b0;
    end else begin
      seen_q       <= seen_d;
      in_payload_q <= in_payload_d;
      accum_q      <= accum_d;
      left_q       <= left_d;
      first_q      <= first_d;
    end
  end

`ifndef SYNTHESIS
  // a frame in progress always has bytes to come
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_payload_q |-> (left_q != 32'd0))
    else $error("payload state with no bytes left");

  // header count rests at zero during payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_payload_q |-> (seen_q == '0))
    else $error("header count not cleared in payload");

  // the last payload byte sends the block back to header
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && res_o.frame_last) |=> !in_payload_q)
    else $error("still in payload after last byte");
`endif

endmodule

// ----- hdl/lpd_queue.sv -----
module lpd_queue import lpd_pkg::*; #(
  parameter int unsigned Depth = QueueDepthDef
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    wr_i,
  input  result_t wr_data_i,
  input  logic    rd_i,
  output result_t rd_data_o,
  output logic    full_o,
  output logic    empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  result_t         mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            do_wr, do_rd;

  assign full_o    = (count_q == CntW'(Depth));
  assign empty_o   = (count_q == '0);
  assign do_wr     = wr_i && !full_o;
  assign do_rd     = rd_i && !empty_o;
  assign rd_data_o = mem_q[rd_ptr_q];

  // pointer and fill count updates
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_wr) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_rd) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (do_wr && !do_rd) begin
      count_d = count_q + CntW'(1);
    end else if (!do_wr && do_rd) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // storage, no reset
  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

`ifndef SYNTHESIS
  // fill count stays within the queue
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(Depth))
    else $error("queue overfilled");

  // pointers meet exactly when empty or full
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wr_ptr_q == rd_ptr_q) == (empty_o || full_o))
    else $error("queue pointers disagree with fill count");

  // never empty and full at once
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(empty_o && full_o))
    else $error("queue both empty and full");
`endif

endmodule
